// ===== src/ksel_pkg.sv =====
// Package for the k-th smallest select unit: sizes of the element store and
// the payload fields, and the command and status records between controller
// and datapath. No dependencies.
package ksel_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int ELEM_W       = 31;
  localparam int RANK_W       = 7;

  typedef struct packed {
    logic take;       // ready on the input channel
    logic init_sel;   // start the first scan pass
    logic rd;         // read the next store entry
    logic next_pass;  // raise the floor to the current pick and rescan
    logic fail;       // record a not-found result
    logic succeed;    // record a found result
    logic emit;       // load the output register, empty the store
  } ksel_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic rank_zero;
    logic addr_end;   // read address is the last stored entry
    logic got;        // a value above the floor was seen this pass
    logic pass_done;  // this pass is the rank-th one
    logic out_free;   // output register can take a beat
  } ksel_stat_t;

endpackage

// ===== src/ksel_in_if.sv =====
// Input channel of the k-th smallest select unit: one list element a beat.
// Depends on ksel_pkg.
interface ksel_in_if
  import ksel_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic [RANK_W-1:0] rank;
  logic              last;

  modport source (output valid, element, rank, last, input ready);
  modport sink   (input valid, element, rank, last, output ready);
endinterface

// ===== src/ksel_out_if.sv =====
// Output channel of the k-th smallest select unit: one result a beat.
// Depends on ksel_pkg.
interface ksel_out_if
  import ksel_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] value;
  logic              found;
  logic              overflow;

  modport source (output valid, value, found, overflow, input ready);
  modport sink   (input valid, value, found, overflow, output ready);
endinterface

// ===== src/kth_smallest_select_unit.sv =====
// Top level of the k-th smallest select unit: controller and datapath.
// Depends on ksel_pkg, ksel_in_if, ksel_out_if, ksel_ctrl and ksel_dp.
//
//   channel  dir  beat carries
//   item     in   element[30:0], rank[6:0], last
//   result   out  value[30:0], found, overflow
//
// Elements load one a cycle between selections. A last element starts
// selection: each pass reads the n stored entries from the store's single
// read port, then drains and decides; up to rank passes run, then the
// result is loaded into the output register (a rank of zero skips the passes).
// Reset is synchronous and empties the list. Loading goes on while a result
// waits; the result load holds, and intake with it, until the output
// register is free.
module kth_smallest_select_unit
  import ksel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ksel_in_if.sink    item,
  ksel_out_if.source result
);

  ksel_cmd_t  cmd;
  ksel_stat_t stat;

  ksel_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  ksel_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

// ===== src/ksel_ctrl.sv =====
// Controller of the k-th smallest select unit: load, scan passes, decide
// and emit sequencing. Depends on ksel_pkg.
module ksel_ctrl
  import ksel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ksel_stat_t stat,
  output ksel_cmd_t  cmd
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.take = 1'b1;
        if (stat.in_valid && stat.in_last) begin
          if (stat.rank_zero) begin
            cmd.fail   = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.init_sel = 1'b1;
            state_next   = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (stat.addr_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (!stat.got) begin
          cmd.fail   = 1'b1;
          state_next = S_EMIT;
        end else if (stat.pass_done) begin
          cmd.succeed = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.next_pass = 1'b1;
          state_next    = S_READ;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

// ===== src/ksel_dp.sv =====
// Datapath of the k-th smallest select unit: element store, count, scan
// registers, minimum compare and output register. Depends on ksel_pkg and
// the channel interfaces.
module ksel_dp
  import ksel_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ksel_in_if.sink    item,
  ksel_out_if.source result,
  input  ksel_cmd_t  cmd,
  output ksel_stat_t stat
);

  logic [ELEM_W-1:0] store [MAX_ELEMENTS];

  logic [CNT_W-1:0]  count;
  logic              overflow_seen;
  logic [ADDR_W-1:0] addr;
  logic [ELEM_W-1:0] rd_data;
  logic              cmp_pending;
  logic [ELEM_W-1:0] floor_val;
  logic              has_floor;
  logic [ELEM_W-1:0] best;
  logic              got;
  logic [RANK_W-1:0] pass_idx;
  logic [RANK_W-1:0] rank_r;
  logic              found_r;
  logic              out_valid;
  logic [ELEM_W-1:0] out_value;
  logic              out_found;
  logic              out_overflow;

  logic load;
  logic has_room;
  logic eligible;
  logic better;

  assign load     = item.valid && cmd.take;
  assign has_room = count < CNT_W'(MAX_ELEMENTS);
  assign eligible = !has_floor || (rd_data > floor_val);
  assign better   = cmp_pending && eligible && (!got || (rd_data < best));

  always_ff @(posedge clk) begin
    if (load && has_room) begin
      store[count[ADDR_W-1:0]] <= item.element;
    end
    rd_data <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      cmp_pending   <= 1'b0;
      got           <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      cmp_pending <= cmd.rd;
      if (cmd.emit) begin
        count         <= '0;
        overflow_seen <= 1'b0;
      end else if (load) begin
        if (has_room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.init_sel || cmd.next_pass) begin
        got <= 1'b0;
      end else if (better) begin
        got <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_sel) begin
      has_floor <= 1'b0;
      pass_idx  <= '0;
      rank_r    <= item.rank;
      addr      <= '0;
    end else if (cmd.next_pass) begin
      has_floor <= 1'b1;
      floor_val <= best;
      pass_idx  <= pass_idx + RANK_W'(1);
      addr      <= '0;
    end else if (cmd.rd) begin
      addr <= addr + ADDR_W'(1);
    end
    if (better) begin
      best <= rd_data;
    end
    if (cmd.fail) begin
      found_r <= 1'b0;
    end else if (cmd.succeed) begin
      found_r <= 1'b1;
    end
    if (cmd.emit) begin
      out_value    <= found_r ? best : '0;
      out_found    <= found_r;
      out_overflow <= overflow_seen;
    end
  end

  assign item.ready      = cmd.take;
  assign result.valid    = out_valid;
  assign result.value    = out_value;
  assign result.found    = out_found;
  assign result.overflow = out_overflow;

  always_comb begin
    stat.in_valid  = item.valid;
    stat.in_last   = item.last;
    stat.rank_zero = item.rank == '0;
    stat.addr_end  = (CNT_W'(addr) + CNT_W'(1)) == count;
    stat.got       = got;
    stat.pass_done = (pass_idx + RANK_W'(1)) == rank_r;
    stat.out_free  = !out_valid || result.ready;
  end

endmodule
